/* rtl/core/pap_pkg.sv */
// Package for the passive-mode reply address parser.
// Holds the scan phase type, the character codes and the result layout.
// No dependencies.
`default_nettype none

package pap_pkg;

	typedef enum logic [2:0] {
		PH_SEEK  = 3'd0,
		PH_NUM   = 3'd1,
		PH_COMMA = 3'd2,
		PH_DONE  = 3'd3
	} scan_phase_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam int         CAPTURE_DEPTH = 5;
	localparam logic [1:0] MAX_DIGITS    = 2'd3;
	localparam logic [2:0] LAST_INDEX    = 3'd5;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USED_W = 49;

endpackage

`default_nettype wire

/* rtl/core/passive_address_parser.sv */
// Passive-mode reply address parser, top level.
// Depends on pap_pkg for the scan phase type and character codes.
//
// The block takes one character of a text line per transaction and looks for
// the first run h1,h2,h3,h4,p1,p2 of six decimal numbers with one to three
// digits each. On the transaction marked by s_axis_tlast it delivers one
// result: found in m_axis_tuser, the address (h1 in the top byte), the port
// p1*256+p2 and an out-of-range flag for any number above 255. Characters
// pass through an input register and a result register, so one character is
// accepted per clock cycle and m_axis_tvalid rises when the last character
// moves from the input register into the result register; only a last
// character whose result register is still occupied waits for m_axis_tready.
// The first character of the next line may be taken while the last one moves on.
`default_nettype none

module passive_address_parser
	import pap_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] char_byte
	input  wire logic                  s_axis_tlast,  // line_end
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [31:0] ip_address,
	                                                  // [47:32] port_number,
	                                                  // [48] out_of_range, rest zero
	output logic                       m_axis_tuser   // found
);

	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s1;
	logic        go_s1;
	logic        out_free;

	scan_phase_t phase_q, phase_a, phase_n;
	logic [1:0]  digits_q, digits_a, digits_n;
	logic [2:0]  index_q, index_a, index_n;
	logic [9:0]  value_q, value_a, value_n;
	logic        range_q, range_a, range_b, range_n;
	logic [7:0]  captured_q [CAPTURE_DEPTH];

	logic        is_digit;
	logic [3:0]  digit_val;
	logic [13:0] value_mac;
	logic        cap_we;
	logic        found_b;

	logic        out_valid_q;
	logic        out_found_q;
	logic [31:0] out_ip_q;
	logic [15:0] out_port_q;
	logic        out_range_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign go_s1         = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	assign is_digit  = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign digit_val = is_digit ? 4'(byte_s1 - CHAR_ZERO) : 4'd0;
	assign value_mac = {value_q, 3'b000} + {3'b000, value_q, 1'b0} + {10'd0, digit_val};

	always_comb begin
		phase_a  = phase_q;
		digits_a = digits_q;
		index_a  = index_q;
		value_a  = value_q;
		range_a  = range_q;
		cap_we   = 1'b0;
		case (phase_q)
			PH_SEEK: begin
				if (is_digit) begin
					phase_a  = PH_NUM;
					digits_a = 2'd1;
					index_a  = 3'd0;
					value_a  = {6'd0, digit_val};
					range_a  = 1'b0;
				end
			end
			PH_NUM: begin
				if (is_digit) begin
					if (digits_q >= MAX_DIGITS) begin
						phase_a  = PH_SEEK;
						digits_a = 2'd0;
						index_a  = 3'd0;
						value_a  = 10'd0;
						range_a  = 1'b0;
					end else begin
						value_a  = value_mac[9:0];
						digits_a = digits_q + 2'd1;
					end
				end else if (index_q >= LAST_INDEX) begin
					range_a = range_q || (value_q[9:8] != 2'b00);
					phase_a = PH_DONE;
				end else if (byte_s1 == CHAR_COMMA) begin
					range_a = range_q || (value_q[9:8] != 2'b00);
					cap_we  = 1'b1;
					index_a = index_q + 3'd1;
					phase_a = PH_COMMA;
				end else begin
					phase_a  = PH_SEEK;
					digits_a = 2'd0;
					index_a  = 3'd0;
					value_a  = 10'd0;
					range_a  = 1'b0;
				end
			end
			PH_COMMA: begin
				if (is_digit) begin
					phase_a  = PH_NUM;
					digits_a = 2'd1;
					value_a  = {6'd0, digit_val};
				end else begin
					phase_a  = PH_SEEK;
					digits_a = 2'd0;
					index_a  = 3'd0;
					value_a  = 10'd0;
					range_a  = 1'b0;
				end
			end
			default: begin
			end
		endcase

		range_b = range_a;
		found_b = (phase_a == PH_DONE);
		if (phase_a == PH_NUM && index_a >= LAST_INDEX) begin
			range_b = range_a || (value_a[9:8] != 2'b00);
			found_b = 1'b1;
		end

		if (last_s1) begin
			phase_n  = PH_SEEK;
			digits_n = 2'd0;
			index_n  = 3'd0;
			value_n  = 10'd0;
			range_n  = 1'b0;
		end else begin
			phase_n  = phase_a;
			digits_n = digits_a;
			index_n  = index_a;
			value_n  = value_a;
			range_n  = range_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK;
			digits_q <= 2'd0;
			index_q  <= 3'd0;
			value_q  <= 10'd0;
			range_q  <= 1'b0;
		end else if (go_s1) begin
			phase_q  <= phase_n;
			digits_q <= digits_n;
			index_q  <= index_n;
			value_q  <= value_n;
			range_q  <= range_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && cap_we) begin
			captured_q[index_q] <= value_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			out_found_q <= found_b;
			if (found_b) begin
				out_ip_q    <= {captured_q[0], captured_q[1], captured_q[2], captured_q[3]};
				out_port_q  <= {captured_q[4], value_a[7:0]};
				out_range_q <= range_b;
			end else begin
				out_ip_q    <= 32'd0;
				out_port_q  <= 16'd0;
				out_range_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_range_q, out_port_q, out_ip_q};

endmodule

`default_nettype wire

/* rtl/core/pap_checker.sv */
// Port-level checker for the passive-mode reply address parser.
// Depends on pap_pkg; bound to passive_address_parser at the end of the file.
`default_nettype none

module pap_checker
	import pap_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  s_axis_tlast,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tuser
);

	logic [1:0] pending_q;
	logic       line_in;
	logic       result_out;

	assign line_in    = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign result_out = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (line_in && !result_out) begin
			pending_q <= pending_q + 2'd1;
		end else if (!line_in && result_out) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("A stalled result transaction changed.");

	a_result_has_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 2'd0)
		else $error("A result was shown without a line end having been accepted.");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("More than two line ends are waiting for results.");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("A result without a match carries nonzero fields.");

	a_padding_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
		else $error("The padding bits of a result are not zero.");

endmodule

bind passive_address_parser pap_checker u_pap_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* dv/pasv_reply_checker.sv */
// Checker for the passive-mode reply address parser.
// Watches both stream channels, predicts each reply from the characters it sees, and counts
// mismatches. Depends on pap_pkg for the scan phase type, character codes and widths.
`default_nettype none

module pasv_reply_checker
	import pap_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic                  s_axis_tlast,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic                  m_axis_tuser,
	output int                         fail_count,
	output int                         pending_results
);

	typedef struct {
		logic        found;
		logic [31:0] ip;
		logic [15:0] port;
		logic        over;
	} pasv_reply_t;

	pasv_reply_t expected_replies[$];

	scan_phase_t phase = PH_SEEK;
	logic [1:0]  ndigits = '0;
	logic [2:0]  nidx = '0;
	logic [9:0]  value = '0;
	logic        over = 1'b0;
	logic [7:0]  caught [CAPTURE_DEPTH];

	initial begin
		fail_count = 0;
		pending_results = 0;
	end

	task automatic drop_candidate();
		phase = PH_SEEK;
		ndigits = '0;
		nidx = '0;
		value = '0;
		over = 1'b0;
	endtask

	task automatic close_sixth();
		if (value > 10'd255) over = 1'b1;
		phase = PH_DONE;
	endtask

	task automatic scan_char(input logic [7:0] ch);
		logic       is_digit;
		logic [3:0] dval;
		is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
		dval = is_digit ? 4'(ch - CHAR_ZERO) : 4'd0;
		case (phase)
			PH_SEEK: begin
				if (is_digit) begin
					drop_candidate();
					phase = PH_NUM;
					ndigits = 2'd1;
					value = 10'(dval);
				end
			end
			PH_NUM: begin
				if (is_digit) begin
					if (ndigits >= MAX_DIGITS) begin
						drop_candidate();
					end else begin
						value = 10'(value * 10 + dval);
						ndigits = ndigits + 2'd1;
					end
				end else if (nidx >= LAST_INDEX) begin
					close_sixth();
				end else if (ch == CHAR_COMMA) begin
					if (value > 10'd255) over = 1'b1;
					caught[nidx] = value[7:0];
					nidx = nidx + 3'd1;
					phase = PH_COMMA;
				end else begin
					drop_candidate();
				end
			end
			PH_COMMA: begin
				if (is_digit) begin
					phase = PH_NUM;
					ndigits = 2'd1;
					value = 10'(dval);
				end else begin
					drop_candidate();
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic close_line();
		pasv_reply_t r;
		if (phase == PH_NUM && nidx >= LAST_INDEX) close_sixth();
		if (phase == PH_DONE) begin
			r.found = 1'b1;
			r.ip = {caught[0], caught[1], caught[2], caught[3]};
			r.port = {caught[4], value[7:0]};
			r.over = over;
		end else begin
			r.found = 1'b0;
			r.ip = '0;
			r.port = '0;
			r.over = 1'b0;
		end
		expected_replies.push_back(r);
		drop_candidate();
	endtask

	task automatic report_failure(input string what);
		if (fail_count < 10) $display("Mismatch: %s", what);
		fail_count++;
	endtask

	always @(posedge clk) begin
		pasv_reply_t r;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				scan_char(s_axis_tdata[7:0]);
				if (s_axis_tlast) close_line();
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_replies.size() == 0) begin
					report_failure($sformatf("unexpected reply found=%0b tdata=%h",
						m_axis_tuser, m_axis_tdata));
				end else begin
					r = expected_replies.pop_front();
					if (m_axis_tuser !== r.found || m_axis_tdata[31:0] !== r.ip ||
					    m_axis_tdata[47:32] !== r.port || m_axis_tdata[48] !== r.over ||
					    m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] !== '0) begin
						report_failure($sformatf({"expected found=%0b ip=%h port=%h over=%0b, ",
							"got found=%0b ip=%h port=%h over=%0b pad=%h"},
							r.found, r.ip, r.port, r.over,
							m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32],
							m_axis_tdata[48], m_axis_tdata[OUT_DATA_W-1:OUT_USED_W]));
					end
				end
			end
			pending_results = expected_replies.size();
		end
	end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Top of the testbench for the passive-mode reply address parser.
// Drives reply lines with random gaps and receiver stalls, and gives the verdict.
// Depends on pap_pkg, passive_address_parser and pasv_reply_checker.
`default_nettype none

module tb_top;
	import pap_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_CHARS = 650;
	localparam int MIN_LINES    = 30;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	int         fail_count;
	int         pending_results;
	int         cycle_count;
	int         chars_sent;
	int         lines;
	logic       hold_go;
	logic       quiet_line;
	logic [7:0] line_buf[$];

	passive_address_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	pasv_reply_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [7:0] pick_text();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return 8'($urandom_range(0, 255));
		if (r < 6) return 8'($urandom_range(65, 90));
		return 8'($urandom_range(32, 47));
	endfunction

	function automatic logic [7:0] pick_digit();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	// Most lines carry a full six-number field inside random text; some break it.
	task automatic build_line();
		int kind;
		int n;
		int digits;
		line_buf.delete();
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			n = $urandom_range(1, 12);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 5);
			repeat (n) line_buf.push_back(pick_text());
			for (int k = 0; k < 6; k++) begin
				digits = $urandom_range(1, 3);
				if ($urandom_range(0, 29) == 0) digits = 4;
				repeat (digits) line_buf.push_back(pick_digit());
				if (k < 5) begin
					if (kind < 30 && $urandom_range(0, 5) == 0) begin
						line_buf.push_back(pick_text());
					end else begin
						line_buf.push_back(CHAR_COMMA);
						if (kind < 30 && $urandom_range(0, 5) == 0)
							line_buf.push_back(pick_text());
					end
				end
			end
			case ($urandom_range(0, 3))
				0: begin
				end
				1: line_buf.push_back(8'h29);
				2: begin
					line_buf.push_back(CHAR_COMMA);
					line_buf.push_back(pick_digit());
				end
				default: begin
					n = $urandom_range(1, 4);
					repeat (n) line_buf.push_back(pick_text());
				end
			endcase
		end
	endtask

	task automatic send_char(input logic [7:0] ch, input logic last);
		int gap;
		gap = 0;
		if (!quiet_line) begin
			gap = $urandom_range(0, 99);
			if (gap < 60) gap = 0;
			else if (gap < 92) gap = $urandom_range(1, 3);
			else gap = $urandom_range(5, 30);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_char(line_buf[i], i == line_buf.size() - 1);
	endtask

	// The receiver mixes random stalls, long ready stretches and one long hold-off.
	initial begin
		int r;
		int ready_run;
		int stall_left;
		ready_run = 0;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_go = 1'b0;
			end
			if (ready_run > 0) begin
				m_axis_tready <= 1'b1;
				ready_run--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) ready_run = $urandom_range(20, 60);
				else if (r < 9) stall_left = $urandom_range(8, 40);
				else m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		hold_go = 1'b0;
		quiet_line = 1'b0;
		chars_sent = 0;
		lines = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		line_buf.delete();
		add_text("999,1,2,3,4,5");
		send_line();
		line_buf.delete();
		add_text("1234");
		send_line();
		line_buf.delete();
		add_text("1,x");
		send_line();
		line_buf.delete();
		add_text("12a");
		send_line();
		line_buf.delete();
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		send_line();
		s_axis_tvalid <= 1'b0;

		while (pending_results != 0) @(negedge clk);

		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS || lines < MIN_LINES) begin
			if (lines == 20) begin
				hold_go = 1'b1;
				quiet_line = 1'b1;
				repeat (12) begin
					line_buf.delete();
					line_buf.push_back(pick_digit());
					send_line();
				end
			end
			quiet_line = ($urandom_range(0, 3) == 0);
			build_line();
			send_line();
			lines++;
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* passive_address_parser.f */
rtl/core/pap_pkg.sv
rtl/core/passive_address_parser.sv
rtl/core/pap_checker.sv
dv/pasv_reply_checker.sv
dv/tb_top.sv
